// ===== hw/rtl/idwseq_pkg.sv =====
// ----------------------------------------------------------------------------
// idwseq_pkg
// shared types and constants for the display write sequencer
// ----------------------------------------------------------------------------
package idwseq_pkg;

  localparam int unsigned PhaseCountW = 5;
  localparam logic [PhaseCountW-1:0] FirstPhase = 5'd0;
  localparam logic [PhaseCountW-1:0] LastPhase  = 5'd28;

  localparam logic [7:0] AddrReset   = 8'h78;
  localparam logic [7:0] CtrlCommand = 8'h00;
  localparam logic [7:0] CtrlData    = 8'h40;

  // bits per byte slot including the acknowledge clock
  localparam logic [4:0] SlotLen = 5'd9;
  localparam logic [3:0] AckSlot = 4'd8;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BIT   = 2'd1,
    PH_ACK   = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    BYTE_ADDR    = 2'd0,
    BYTE_CONTROL = 2'd1,
    BYTE_PAYLOAD = 2'd2
  } byte_sel_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] payload;
  } req_t;

  typedef struct packed {
    phase_e phase;
    logic   sda_level;
    logic   last;
  } bus_phase_t;

endpackage

// ===== hw/rtl/idwseq_req_stage.sv =====
// ----------------------------------------------------------------------------
// idwseq_req_stage
// holds the request being sequenced, takes the next one as it is released
// ----------------------------------------------------------------------------
module idwseq_req_stage
  import idwseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] payload_i,
  input  logic       release_i,
  output logic       req_valid_o,
  output req_t       req_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic accept;

  assign in_ready_o = !valid_q || release_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (release_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.mode    <= mode_i;
      req_q.payload <= payload_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ===== hw/rtl/idwseq_phase_decode.sv =====
// ----------------------------------------------------------------------------
// idwseq_phase_decode
// maps a phase index and the request onto one bus phase
// ----------------------------------------------------------------------------
module idwseq_phase_decode
  import idwseq_pkg::*;
(
  input  logic [PhaseCountW-1:0] phase_idx_i,
  input  req_t                   req_i,
  input  logic [7:0]             slave_addr_i,
  output bus_phase_t             bus_phase_o
);

  logic [PhaseCountW-1:0] slot_idx;
  byte_sel_e              byte_sel;
  logic [PhaseCountW-1:0] slot_base;
  logic [PhaseCountW-1:0] bit_off_full;
  logic [3:0]             bit_off;
  logic [2:0]             bit_pos;
  logic [7:0]             byte_val;
  logic                   lsb_first;

  // index inside the 27 byte and acknowledge slots
  assign slot_idx = phase_idx_i - 5'd1;

  always_comb begin
    if (slot_idx < SlotLen) begin
      byte_sel  = BYTE_ADDR;
      slot_base = 5'd0;
    end else if (slot_idx < (SlotLen + SlotLen)) begin
      byte_sel  = BYTE_CONTROL;
      slot_base = SlotLen;
    end else begin
      byte_sel  = BYTE_PAYLOAD;
      slot_base = SlotLen + SlotLen;
    end
  end

  assign bit_off_full = slot_idx - slot_base;
  assign bit_off      = bit_off_full[3:0];

  always_comb begin
    case (byte_sel)
      BYTE_ADDR:    byte_val = slave_addr_i;
      BYTE_CONTROL: byte_val = (req_i.mode != 2'd0) ? CtrlData : CtrlCommand;
      BYTE_PAYLOAD: byte_val = req_i.payload;
      default:      byte_val = req_i.payload;
    endcase
  end

  // mode bit 1 reverses the payload byte only
  assign lsb_first = (byte_sel == BYTE_PAYLOAD) && req_i.mode[1];
  assign bit_pos   = lsb_first ? bit_off[2:0] : (3'd7 - bit_off[2:0]);

  always_comb begin
    bus_phase_o.last = 1'b0;
    if (phase_idx_i == FirstPhase) begin
      bus_phase_o.phase     = PH_START;
      bus_phase_o.sda_level = 1'b0;
    end else if (phase_idx_i == LastPhase) begin
      bus_phase_o.phase     = PH_STOP;
      bus_phase_o.sda_level = 1'b1;
      bus_phase_o.last      = 1'b1;
    end else if (bit_off == AckSlot) begin
      bus_phase_o.phase     = PH_ACK;
      bus_phase_o.sda_level = 1'b1;
    end else begin
      bus_phase_o.phase     = PH_BIT;
      bus_phase_o.sda_level = byte_val[bit_pos];
    end
  end

endmodule

// ===== hw/rtl/idwseq_out_stage.sv =====
// ----------------------------------------------------------------------------
// idwseq_out_stage
// result register in front of the output handshake
// ----------------------------------------------------------------------------
module idwseq_out_stage
  import idwseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_valid_i,
  input  bus_phase_t load_phase_i,
  output logic       advance_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] phase_o,
  output logic       sda_level_o,
  output logic       last_o
);

  logic       valid_q;
  bus_phase_t phase_q;

  // register may be refilled when empty or when its contents leave now
  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_valid_i) begin
      phase_q <= load_phase_i;
    end
  end

  assign out_valid_o = valid_q;
  assign phase_o     = phase_q.phase;
  assign sda_level_o = phase_q.sda_level;
  assign last_o      = phase_q.last;

endmodule

// ===== hw/rtl/i2c_display_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_display_write_sequencer
// turns one display write request into the bus phases of an i2c write
// ----------------------------------------------------------------------------
// Each accepted request produces 29 output items, one per bus phase: start,
// the slave address byte MSB first and an acknowledge clock, the control byte
// (0x00 for a command, 0x40 for data) and an acknowledge clock, the payload
// byte (LSB first when mode bit 1 is set) and an acknowledge clock, then stop,
// which is flagged by last_o. The phase counter emits one phase per cycle
// while out_ready_i does not stall the result register; with out_ready_i held
// high requests stream back to back, as the next request is taken into the
// request register in the same cycle the stop phase is loaded. When idle, an
// accepted request passes the request register and then the result register
// before the start phase appears. The slave address register resets to 0x78
// and must only be written while no request is in flight. The acknowledge
// clocks release SDA and the reply is not checked.
// ----------------------------------------------------------------------------
module i2c_display_write_sequencer
  import idwseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] payload_i,
  // bus phase channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] phase_o,
  output logic       sda_level_o,
  output logic       last_o
);

  logic [7:0]             slave_addr_q;
  logic [PhaseCountW-1:0] phase_idx_q, phase_idx_d;
  logic                   req_valid;
  req_t                   req;
  logic                   advance;
  logic                   step;
  logic                   release_req;
  bus_phase_t             next_phase;

  // slave address register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= AddrReset;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  idwseq_req_stage u_req_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .payload_i   (payload_i),
    .release_i   (release_req),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // one phase moves into the result register per step
  assign step        = advance && req_valid;
  assign release_req = step && (phase_idx_q == LastPhase);

  always_comb begin
    phase_idx_d = phase_idx_q;
    if (release_req) begin
      phase_idx_d = FirstPhase;
    end else if (step) begin
      phase_idx_d = phase_idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_idx_q <= FirstPhase;
    end else begin
      phase_idx_q <= phase_idx_d;
    end
  end

  idwseq_phase_decode u_phase_decode (
    .phase_idx_i  (phase_idx_q),
    .req_i        (req),
    .slave_addr_i (slave_addr_q),
    .bus_phase_o  (next_phase)
  );

  idwseq_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (req_valid),
    .load_phase_i (next_phase),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_o      (phase_o),
    .sda_level_o  (sda_level_o),
    .last_o       (last_o)
  );

endmodule

// ===== hw/rtl/idwseq_checker.sv =====
// ----------------------------------------------------------------------------
// idwseq_checker
// port level checks for the display write sequencer
// ----------------------------------------------------------------------------
module idwseq_checker
  import idwseq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] phase_o,
  input logic       sda_level_o,
  input logic       last_o
);

  // last marks the stop phase and nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (phase_o == PH_STOP)))
    else $error("last flag does not match stop phase");

  // start pulls sda low, acknowledge and stop release it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PH_START) |-> !sda_level_o)
    else $error("start phase with sda released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((phase_o == PH_ACK) || (phase_o == PH_STOP)) |-> sda_level_o)
    else $error("acknowledge or stop phase with sda driven low");

  // a taken start is always followed at once by the first address bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (phase_o == PH_START)
    |=> out_valid_o && (phase_o == PH_BIT))
    else $error("start phase not followed by a data bit");

endmodule

bind i2c_display_write_sequencer idwseq_checker u_idwseq_checker (.*);

// ===== sim/i2c_display_write_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_display_write_sequencer_tb
// self-checking bench for the display write sequencer
// ----------------------------------------------------------------------------
// Drives display write requests with random gaps and random back-pressure on
// the bus phase channel. A small scoreboard expands every accepted request
// into its 29 bus phases and compares the phases that come out, in order.
// The slave address register is rewritten between groups of requests,
// only while nothing is in flight.
// ----------------------------------------------------------------------------

import idwseq_pkg::*;

class bus_phase_board;
  bus_phase_t  expected_q[$];
  logic [7:0]  slave_addr;
  int unsigned requests;
  int unsigned phases;
  int unsigned mismatches;

  function new();
    slave_addr = AddrReset;
    requests   = 0;
    phases     = 0;
    mismatches = 0;
  endfunction

  function void push_phase(phase_e ph, logic sda, logic lst);
    bus_phase_t p;
    p.phase     = ph;
    p.sda_level = sda;
    p.last      = lst;
    expected_q.push_back(p);
  endfunction

  // eight bit slots then the acknowledge clock, which releases sda
  function void push_byte(logic [7:0] value, logic lsb_first);
    for (int i = 0; i < 8; i++) begin
      push_phase(PH_BIT, lsb_first ? value[i] : value[7-i], 1'b0);
    end
    push_phase(PH_ACK, 1'b1, 1'b0);
  endfunction

  // mode is decoded bitwise: any nonzero mode picks the data control byte,
  // bit 1 alone picks lsb-first payload order
  function void note_request(logic [1:0] mode, logic [7:0] payload);
    logic [7:0] control;
    control = (mode != 2'd0) ? CtrlData : CtrlCommand;
    requests++;
    push_phase(PH_START, 1'b0, 1'b0);
    push_byte(slave_addr, 1'b0);
    push_byte(control, 1'b0);
    push_byte(payload, mode[1]);
    push_phase(PH_STOP, 1'b1, 1'b1);
  endfunction

  function void check_phase(logic [1:0] phase, logic sda, logic lst);
    bus_phase_t want;
    phases++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected bus phase %0d sda %0b last %0b, nothing outstanding",
                 phase, sda, lst);
      return;
    end
    want = expected_q.pop_front();
    if (want.phase !== phase || want.sda_level !== sda || want.last !== lst) begin
      mismatches++;
      if (mismatches <= 10)
        $display("bus phase %0d: expected phase %0d sda %0b last %0b, got %0d %0b %0b",
                 phases, want.phase, want.sda_level, want.last, phase, sda, lst);
    end
  endfunction
endclass

module i2c_display_write_sequencer_tb;

  // request modes as seen on mode_i
  localparam logic [1:0] ModeCommand = 2'd0;
  localparam logic [1:0] ModeDataMsb = 2'd1;
  localparam logic [1:0] ModeDataLsb = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  localparam int unsigned IdlePercent = 13;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandRounds  = 5;
  localparam int unsigned RoundLen    = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] mode_i;
  logic [7:0] payload_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] phase_o;
  logic       sda_level_o;
  logic       last_o;

  // high while both sides run without any idling
  logic        steady;
  int unsigned cycle_count = 0;
  int unsigned addr_settings;

  bus_phase_board board = new();

  i2c_display_write_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .payload_i   (payload_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .phase_o     (phase_o),
    .sda_level_o (sda_level_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bus phase side: random stalls, none during the steady stretch
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IdlePercent);
  end

  // outputs are sampled as they stood before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_phase(phase_o, sda_level_o, last_o);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run stopped at the cycle limit of %0d", CycleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // one request: optional idle cycles, then hold valid until taken
  task automatic send_request(input logic [1:0] mode, input logic [7:0] payload);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      mode_i     <= 2'($urandom_range(3));
      payload_i  <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    payload_i  <= payload;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(mode, payload);
  endtask

  // let every outstanding phase come out, then rewrite the slave address
  task automatic set_slave_addr(input logic [7:0] addr);
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.slave_addr = addr;
    addr_settings++;
  endtask

  initial begin
    int unsigned steady_round;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    in_valid_i    <= 1'b0;
    mode_i        <= ModeCommand;
    payload_i     <= 8'h00;
    steady        <= 1'b0;
    addr_settings = 1;
    steady_round  = $urandom_range(RandRounds - 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part under the reset address: every mode and both bit orders, with
    // all-zero, all-one, single-bit and single-zero payloads
    send_request(ModeCommand, 8'h00);
    send_request(ModeCommand, 8'hFF);
    send_request(ModeDataMsb, 8'h00);
    send_request(ModeDataMsb, 8'hFF);
    send_request(ModeDataLsb, 8'h01);
    send_request(ModeDataLsb, 8'h80);
    send_request(ModeDataMsb, 8'h80);
    send_request(ModeDataMsb, 8'h01);
    send_request(ModeDataLsb, 8'hFE);
    send_request(ModeCommand, 8'h7F);
    // unused mode falls back to lsb-first data
    send_request(ModeUnused, 8'hA5);
    send_request(ModeUnused, 8'h5A);

    // address extremes
    set_slave_addr(8'h00);
    send_request(ModeCommand, 8'hC3);
    send_request(ModeDataMsb, 8'h3C);
    send_request(ModeDataLsb, 8'h96);
    send_request(ModeUnused, 8'h69);
    set_slave_addr(8'hFF);
    send_request(ModeCommand, 8'h0F);
    send_request(ModeDataMsb, 8'hF0);
    send_request(ModeDataLsb, 8'h11);
    send_request(ModeUnused, 8'hEE);

    // random rounds, each under a fresh address; one round runs with no idling
    for (int r = 0; r < RandRounds; r++) begin
      set_slave_addr(8'($urandom_range(255)));
      steady <= (r == steady_round);
      for (int n = 0; n < RoundLen; n++) begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end

    in_valid_i <= 1'b0;
    steady     <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d write requests under %0d slave addresses, %0d bus phases checked",
             board.requests, addr_settings, board.phases);
    $display("%0d mismatches, %0d phases still outstanding",
             board.mismatches, board.expected_q.size());
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/idwseq_pkg.sv
hw/rtl/idwseq_req_stage.sv
hw/rtl/idwseq_phase_decode.sv
hw/rtl/idwseq_out_stage.sv
hw/rtl/i2c_display_write_sequencer.sv
hw/rtl/idwseq_checker.sv
sim/i2c_display_write_sequencer_tb.sv
